FILE: sv/fdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_pkg
// Shared constants and types of the frame difference dirty-rectangle block.
// ----------------------------------------------------------------------------
package fdd_pkg;

  localparam int PANEL_WIDTH  = 152;
  localparam int PANEL_HEIGHT = 296;
  localparam int ROW_BYTES    = PANEL_WIDTH / 8;
  localparam int STORE_DEPTH  = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  localparam int COL_W  = 5;
  localparam int ROW_W  = 9;
  localparam int BYTE_W = 8;
  localparam int MODE_W = 2;
  localparam int RX_W   = 9;
  localparam int RY_W   = 8;
  localparam int RW_W   = 9;
  localparam int RH_W   = 8;

  // Box area times four is compared against three quarters of the panel.
  localparam int AREA_W     = COL_W + ROW_W + 5;
  localparam int FULL_LIMIT = 3 * PANEL_WIDTH * PANEL_HEIGHT;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic REG_ROTATION = 1'b0;
  localparam logic REG_PARTIAL  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PARTIAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FULL    = 2'd2;

  typedef struct packed {
    logic rotation_select;
    logic partial_enable;
  } fdd_cfg_t;

  // Box and settings captured on the last byte of a frame.
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] first_col;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
    logic             change_seen;
    logic             comparable;
    logic             allow;
    logic             rotation;
  } fdd_snap_t;

  typedef struct packed {
    logic snap_busy;
    logic out_busy;
  } fdd_status_t;

endpackage

FILE: sv/fdd_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd channels
// Valid/ready stream interfaces for frame bytes and refresh requests.
// ----------------------------------------------------------------------------
interface fdd_in_if;
  import fdd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;
  logic              frame_end;
  modport source (output valid, output pixel_byte, output frame_end, input ready);
  modport sink   (input valid, input pixel_byte, input frame_end, output ready);
endinterface

interface fdd_out_if;
  import fdd_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] refresh_mode;
  logic [RX_W-1:0]   region_x;
  logic [RY_W-1:0]   region_y;
  logic [RW_W-1:0]   region_width;
  logic [RH_W-1:0]   region_height;
  modport source (output valid, output refresh_mode, output region_x, output region_y,
                  output region_width, output region_height, input ready);
  modport sink   (input valid, input refresh_mode, input region_x, input region_y,
                  input region_width, input region_height, output ready);
endinterface

FILE: sv/fdd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/fdd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_cfg
// APB register file holding the rotation and partial refresh settings.
// ----------------------------------------------------------------------------
module fdd_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [fdd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fdd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fdd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output fdd_pkg::fdd_cfg_t         cfg
);
  import fdd_pkg::*;

  logic rotation_r, rotation_nxt;
  logic partial_r, partial_nxt;
  logic wr_en;
  logic reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[2];

  always_comb begin
    rotation_nxt = rotation_r;
    partial_nxt  = partial_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ROTATION: rotation_nxt = cfg_pwdata[0];
        REG_PARTIAL:  partial_nxt  = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROTATION: cfg_prdata = {{(CFG_DW-1){1'b0}}, rotation_r};
      REG_PARTIAL:  cfg_prdata = {{(CFG_DW-1){1'b0}}, partial_r};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= 1'b0;
      partial_r  <= 1'b0;
    end else begin
      rotation_r <= rotation_nxt;
      partial_r  <= partial_nxt;
    end
  end

  assign cfg.rotation_select = rotation_r;
  assign cfg.partial_enable  = partial_r;

endmodule

FILE: sv/fdd_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_track
// Raster counters, previous-frame store access and changed-byte box tracking.
// ----------------------------------------------------------------------------
module fdd_track (
  input  logic                  clk,
  input  logic                  rst_n,
  fdd_in_if.sink                in_ch,
  input  fdd_pkg::fdd_cfg_t     cfg,
  input  fdd_pkg::fdd_status_t  status,
  output fdd_pkg::fdd_snap_t    snap
);
  import fdd_pkg::*;

  // Raster position of the next byte to arrive.
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  // Compare stage: the byte whose stored copy is being read back.
  logic              s1_v_r, s1_end_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              fwd_r, fwd_nxt;
  logic [BYTE_W-1:0] fwd_data_r;

  logic [COL_W-1:0]  fc_r, lc_r, fc_cur, lc_cur;
  logic [ROW_W-1:0]  fr_r, lr_r, fr_cur, lr_cur;
  logic              seen_r, seen_cur;
  logic              prev_valid_r, prev_rot_r;

  logic              accept;
  logic [1:0]        pending;
  logic [BYTE_W-1:0] rdata, old_byte;
  logic              changed, s1_done_end;

  assign pending = 2'(s1_v_r && s1_end_r) + 2'(status.snap_busy) + 2'(status.out_busy);
  assign in_ch.ready = (pending < 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    addr_nxt = addr_r;
    if (accept) begin
      if (in_ch.frame_end) begin
        col_nxt  = '0;
        row_nxt  = '0;
        addr_nxt = '0;
      end else if (col_r == COL_W'(ROW_BYTES - 1)) begin
        col_nxt = '0;
        if (row_r == ROW_W'(PANEL_HEIGHT - 1)) begin
          row_nxt  = '0;
          addr_nxt = '0;
        end else begin
          row_nxt  = row_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end else begin
        col_nxt  = col_r + 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
    end
  end

  // The byte in the compare stage is written back on the same edge that the
  // next byte's read is taken, so a read of that entry gets the new byte here.
  assign fwd_nxt = accept && s1_v_r && (s1_addr_r == addr_r);

  fdd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_addr_r),
    .wdata (s1_byte_r),
    .re    (accept),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign old_byte    = fwd_r ? fwd_data_r : rdata;
  assign changed     = s1_v_r && (old_byte != s1_byte_r);
  assign s1_done_end = s1_v_r && s1_end_r;

  always_comb begin
    fc_cur   = fc_r;
    lc_cur   = lc_r;
    fr_cur   = fr_r;
    lr_cur   = lr_r;
    seen_cur = seen_r;
    if (changed) begin
      seen_cur = 1'b1;
      if (!seen_r) begin
        fc_cur = s1_col_r;
        lc_cur = s1_col_r;
        fr_cur = s1_row_r;
        lr_cur = s1_row_r;
      end else begin
        if (s1_col_r < fc_r) fc_cur = s1_col_r;
        if (s1_col_r > lc_r) lc_cur = s1_col_r;
        if (s1_row_r < fr_r) fr_cur = s1_row_r;
        if (s1_row_r > lr_r) lr_cur = s1_row_r;
      end
    end
  end

  always_comb begin
    snap.valid       = s1_done_end;
    snap.first_col   = fc_cur;
    snap.last_col    = lc_cur;
    snap.top_row     = fr_cur;
    snap.bottom_row  = lr_cur;
    snap.change_seen = seen_cur;
    snap.comparable  = prev_valid_r && (prev_rot_r == cfg.rotation_select);
    snap.allow       = cfg.partial_enable;
    snap.rotation    = cfg.rotation_select;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      addr_r       <= '0;
      s1_v_r       <= 1'b0;
      fwd_r        <= 1'b0;
      fc_r         <= '1;
      lc_r         <= '0;
      fr_r         <= '1;
      lr_r         <= '0;
      seen_r       <= 1'b0;
      prev_valid_r <= 1'b0;
      prev_rot_r   <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      addr_r <= addr_nxt;
      s1_v_r <= accept;
      fwd_r  <= fwd_nxt;
      if (s1_done_end) begin
        fc_r         <= '1;
        lc_r         <= '0;
        fr_r         <= '1;
        lr_r         <= '0;
        seen_r       <= 1'b0;
        prev_valid_r <= 1'b1;
        prev_rot_r   <= cfg.rotation_select;
      end else begin
        fc_r   <= fc_cur;
        lc_r   <= lc_cur;
        fr_r   <= fr_cur;
        lr_r   <= lr_cur;
        seen_r <= seen_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_end_r   <= in_ch.frame_end;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_addr_r  <= addr_r;
      s1_byte_r  <= in_ch.pixel_byte;
      fwd_data_r <= s1_byte_r;
    end
  end

  a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    addr_r < ADDR_W'(STORE_DEPTH))
    else $error("store address past the end of the frame");

  a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_v_r)
    else $error("forwarding flagged with no byte in the compare stage");

  a_box_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_done_end |=> (!seen_r && fc_r == '1 && fr_r == '1 && lc_r == '0 && lr_r == '0))
    else $error("box not cleared after the end of a frame");

endmodule

FILE: sv/fdd_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_decide
// Turns a captured box into a refresh request and holds it for the receiver.
// ----------------------------------------------------------------------------
module fdd_decide (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fdd_pkg::fdd_snap_t    snap,
  output fdd_pkg::fdd_status_t  status,
  fdd_out_if.source             out_ch
);
  import fdd_pkg::*;

  fdd_snap_t         snap_r;
  logic              snap_v_r, snap_v_nxt;
  logic              out_v_r, out_v_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [RX_W-1:0]   rx_r, rx_nxt;
  logic [RY_W-1:0]   ry_r, ry_nxt;
  logic [RW_W-1:0]   rw_r, rw_nxt;
  logic [RH_W-1:0]   rh_r, rh_nxt;

  logic                   advance;
  logic [COL_W-1:0]       bytes;
  logic [ROW_W-1:0]       rows;
  logic [COL_W+ROW_W-1:0] prod;
  logic [AREA_W-1:0]      area4;
  logic                   too_big, partial_ok;
  logic [RY_W-1:0]        xs, xe;

  assign advance = snap_v_r && (!out_v_r || out_ch.ready);

  assign bytes = snap_r.last_col - snap_r.first_col + 1'b1;
  assign rows  = snap_r.bottom_row - snap_r.top_row + 1'b1;
  assign prod  = bytes * rows;
  // Pixel area is bytes * 8 * rows; four times that is the product shifted by five.
  assign area4   = {AREA_W'(prod)} << 5;
  assign too_big = (area4 >= AREA_W'(FULL_LIMIT));
  assign xs      = {snap_r.first_col, 3'b000};
  assign xe      = {snap_r.last_col, 3'b111};
  assign partial_ok = snap_r.allow && snap_r.comparable;

  always_comb begin
    mode_nxt = MODE_FULL;
    rx_nxt   = '0;
    ry_nxt   = '0;
    rw_nxt   = RW_W'(PANEL_HEIGHT);
    rh_nxt   = RH_W'(PANEL_WIDTH);
    if (partial_ok && !snap_r.change_seen) begin
      mode_nxt = MODE_NONE;
      rw_nxt   = '0;
      rh_nxt   = '0;
    end else if (partial_ok && !too_big) begin
      mode_nxt = MODE_PARTIAL;
      rw_nxt   = rows;
      rh_nxt   = {bytes, 3'b000};
      if (snap_r.rotation) begin
        rx_nxt = snap_r.top_row;
        ry_nxt = RY_W'(PANEL_WIDTH - 1) - xe;
      end else begin
        rx_nxt = RX_W'(PANEL_HEIGHT - 1) - snap_r.bottom_row;
        ry_nxt = xs;
      end
    end
  end

  always_comb begin
    snap_v_nxt = snap_v_r;
    if (advance) snap_v_nxt = 1'b0;
    if (snap.valid) snap_v_nxt = 1'b1;
    out_v_nxt = out_v_r;
    if (out_ch.ready) out_v_nxt = 1'b0;
    if (advance) out_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap.valid) begin
      snap_r <= snap;
    end
    if (advance) begin
      mode_r <= mode_nxt;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      rw_r   <= rw_nxt;
      rh_r   <= rh_nxt;
    end
  end

  assign status.snap_busy     = snap_v_r;
  assign status.out_busy      = out_v_r;
  assign out_ch.valid         = out_v_r;
  assign out_ch.refresh_mode  = mode_r;
  assign out_ch.region_x      = rx_r;
  assign out_ch.region_y      = ry_r;
  assign out_ch.region_width  = rw_r;
  assign out_ch.region_height = rh_r;

  a_snap_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    snap.valid |-> (!snap_v_r || advance))
    else $error("frame end arrived while the decision stage was full");

  a_none_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && mode_r == MODE_NONE) |-> (rw_r == '0 && rh_r == '0))
    else $error("no-refresh request carries a region");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (mode_r == MODE_NONE || mode_r == MODE_PARTIAL || mode_r == MODE_FULL))
    else $error("illegal refresh mode");

endmodule

FILE: sv/frame_diff_dirty_rectangle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_diff_dirty_rectangle
// Compares each frame with the previous one and requests a panel refresh.
// ----------------------------------------------------------------------------
// Frame bytes arrive on in_ch (pixel_byte, frame_end) in raster order, one
// byte per cycle while in_ch.ready is high. Each byte is checked against the
// stored previous frame and written back; the read/modify/write pipeline
// around the single-port-per-direction store sustains one byte per cycle.
// On the frame_end byte one refresh request leaves on out_ch: none, a
// partial region in landscape coordinates, or a full refresh. The request
// passes the compare stage, the decision slot and the output register, and
// can wait in the decision slot while the output register is held.
// A frame_end byte in the compare stage, the decision slot and the output
// register each count as a pending request; in_ch.ready drops while two are
// pending. Frames of one or two bytes in a row therefore see stall cycles
// even with an always-ready receiver, and a stalled receiver holds up input
// once one request waits and another frame ends. A stalled request holds.
// Reset clears the settings, the box and the counters, and marks the
// previous frame as absent, so the first request after reset is full.
// The store needs no clearing pass. Settings are written over the APB-style
// cfg_ port: rotation at address 0, partial enable at address 4.
// ----------------------------------------------------------------------------
module frame_diff_dirty_rectangle (
  input  logic                       clk,
  input  logic                       rst_n,
  fdd_in_if.sink                     in_ch,
  fdd_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [fdd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fdd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fdd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import fdd_pkg::*;

  fdd_cfg_t    cfg;
  fdd_snap_t   snap;
  fdd_status_t status;

  fdd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fdd_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .status (status),
    .snap   (snap)
  );

  fdd_decide u_decide (
    .clk    (clk),
    .rst_n  (rst_n),
    .snap   (snap),
    .status (status),
    .out_ch (out_ch)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_diff_dirty_rectangle.
// ----------------------------------------------------------------------------
// Frame bytes are queued by a stimulus process and driven with random gaps.
// Every accepted byte goes through a behavioral copy of the detector that
// keeps its own previous frame, change box and settings, and each frame end
// adds the expected refresh request to a queue. Requests leaving the block
// are compared field by field against that queue. The first frame after
// reset is the longest one, so every stored byte that a later frame
// compares against has been written. Directed frames cover the none,
// partial and full cases in both rotations; most random frames are short.
// ----------------------------------------------------------------------------
module tb;
  import fdd_pkg::*;

  localparam int MAX_FRAME = 120;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [RX_W-1:0]   x;
    logic [RY_W-1:0]   y;
    logic [RW_W-1:0]   w;
    logic [RH_W-1:0]   h;
  } refresh_req_t;

  typedef struct {
    logic [BYTE_W-1:0] pix;
    logic              fend;
    int                gap;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  fdd_in_if  in_if ();
  fdd_out_if out_if ();

  frame_diff_dirty_rectangle dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Behavioral copy of the detector.
  bit   [BYTE_W-1:0] last_frame [STORE_DEPTH];
  logic              last_valid;
  logic              last_rot;
  logic              cfg_rot;
  logic              cfg_part;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  box_col_lo;
  logic [COL_W-1:0]  box_col_hi;
  logic [ROW_W-1:0]  box_row_lo;
  logic [ROW_W-1:0]  box_row_hi;
  logic              box_seen;

  refresh_req_t expected_refresh [$];

  // Stimulus side: bytes waiting to be driven and the image sent so far.
  frame_byte_t       byte_queue [$];
  logic [BYTE_W-1:0] sent_image [STORE_DEPTH];
  int                gen_pos;
  int                flip_marks [$];
  bit                sender_idle;
  bit                receiver_idle;
  bit                hold_on;
  int                tx_wait;
  int                rx_wait;

  int errors;
  int frames_queued;
  int bytes_accepted;
  int cfg_writes;
  int mode_count [4];

  task automatic clear_box();
    cur_col    = '0;
    cur_row    = '0;
    box_col_lo = '1;
    box_col_hi = '0;
    box_row_lo = '1;
    box_row_hi = '0;
    box_seen   = 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input int unsigned expv,
                               input int unsigned actv);
    if (errors < 10)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, expv, actv);
    errors++;
  endtask

  // Compares one byte with the previous frame, grows the box, and on the
  // last byte of a frame works out the refresh request.
  task automatic track_byte(input logic [BYTE_W-1:0] pix, input logic fend);
    int           addr;
    int           xs;
    int           xe;
    int           ys;
    int           ye;
    refresh_req_t req;
    addr = int'(cur_row) * ROW_BYTES + int'(cur_col);
    if (addr < STORE_DEPTH) begin
      if (last_frame[addr] != pix) begin
        if (!box_seen) begin
          box_col_lo = cur_col;
          box_col_hi = cur_col;
          box_row_lo = cur_row;
          box_row_hi = cur_row;
          box_seen   = 1'b1;
        end else begin
          if (cur_col < box_col_lo) box_col_lo = cur_col;
          if (cur_col > box_col_hi) box_col_hi = cur_col;
          if (cur_row < box_row_lo) box_row_lo = cur_row;
          if (cur_row > box_row_hi) box_row_hi = cur_row;
        end
      end
      last_frame[addr] = pix;
    end
    if (!fend) begin
      if (int'(cur_col) >= ROW_BYTES - 1) begin
        cur_col = '0;
        if (int'(cur_row) >= PANEL_HEIGHT - 1) cur_row = '0;
        else cur_row = cur_row + 1'b1;
      end else begin
        cur_col = cur_col + 1'b1;
      end
    end else begin
      req = '{MODE_FULL, '0, '0, RW_W'(PANEL_HEIGHT), RH_W'(PANEL_WIDTH)};
      if (cfg_part && last_valid && last_rot == cfg_rot) begin
        if (!box_seen) begin
          req = '{MODE_NONE, '0, '0, '0, '0};
        end else begin
          xs = int'(box_col_lo) * 8;
          xe = int'(box_col_hi) * 8 + 7;
          ys = int'(box_row_lo);
          ye = int'(box_row_hi);
          if (4 * (xe - xs + 1) * (ye - ys + 1) < 3 * PANEL_WIDTH * PANEL_HEIGHT) begin
            req.mode = MODE_PARTIAL;
            req.w    = RW_W'(ye - ys + 1);
            req.h    = RH_W'(xe - xs + 1);
            if (cfg_rot) begin
              req.x = RX_W'(ys);
              req.y = RY_W'(PANEL_WIDTH - 1 - xe);
            end else begin
              req.x = RX_W'(PANEL_HEIGHT - 1 - ye);
              req.y = RY_W'(xs);
            end
          end
        end
      end
      expected_refresh.push_back(req);
      last_valid = 1'b1;
      last_rot   = cfg_rot;
      clear_box();
    end
  endtask

  // Byte driver. Each byte waits its own number of idle cycles first.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.pixel_byte <= '0;
      in_if.frame_end  <= 1'b0;
      tx_wait          <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (byte_queue.size() != 0 && tx_wait >= byte_queue[0].gap) begin
        in_if.valid      <= 1'b1;
        in_if.pixel_byte <= byte_queue[0].pix;
        in_if.frame_end  <= byte_queue[0].fend;
        tx_wait          <= 0;
        void'(byte_queue.pop_front());
      end else begin
        in_if.valid <= 1'b0;
        if (byte_queue.size() != 0) tx_wait <= tx_wait + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      track_byte(in_if.pixel_byte, in_if.frame_end);
      bytes_accepted++;
    end
  end

  // Request receiver and checker.
  always @(posedge clk) begin : request_sink
    int           w;
    refresh_req_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_wait      <= 0;
    end else begin
      w = rx_wait;
      if (out_if.valid && out_if.ready) begin
        mode_count[out_if.refresh_mode]++;
        if (expected_refresh.size() == 0) begin
          flag_mismatch("request with none pending, mode", 0, out_if.refresh_mode);
        end else begin
          e = expected_refresh.pop_front();
          if (out_if.refresh_mode !== e.mode)
            flag_mismatch("refresh_mode", e.mode, out_if.refresh_mode);
          if (out_if.region_x !== e.x)
            flag_mismatch("region_x", e.x, out_if.region_x);
          if (out_if.region_y !== e.y)
            flag_mismatch("region_y", e.y, out_if.region_y);
          if (out_if.region_width !== e.w)
            flag_mismatch("region_width", e.w, out_if.region_width);
          if (out_if.region_height !== e.h)
            flag_mismatch("region_height", e.h, out_if.region_height);
        end
        w = receiver_idle ? int'($urandom_range(0, 11)) : 0;
      end
      if (hold_on) begin
        out_if.ready <= 1'b0;
        rx_wait      <= w;
      end else if (w > 0) begin
        out_if.ready <= 1'b0;
        rx_wait      <= w - 1;
      end else begin
        out_if.ready <= 1'b1;
        rx_wait      <= 0;
      end
    end
  end

  task automatic set_register(input logic idx, input logic val);
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] rd;
    addr = {idx, 2'b00};
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= CFG_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_ROTATION) cfg_rot = val;
    else cfg_part = val;
    cfg_writes++;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== CFG_DW'(val)) flag_mismatch("register read back", val, rd);
  endtask

  // Queues one frame built from the image already sent. Bytes change at
  // random with the given rate per thousand, and always at the frame offsets
  // listed in flip_marks (ascending).
  task automatic queue_frame(input int nbytes, input int flip_pm);
    frame_byte_t fb;
    for (int k = 0; k < nbytes; k++) begin
      fb.pix = sent_image[gen_pos];
      if (flip_marks.size() != 0 && flip_marks[0] == k) begin
        void'(flip_marks.pop_front());
        fb.pix = fb.pix ^ BYTE_W'($urandom_range(1, 255));
      end else if (int'($urandom_range(0, 999)) < flip_pm) begin
        fb.pix = fb.pix ^ BYTE_W'($urandom_range(1, 255));
      end
      fb.fend = (k == nbytes - 1);
      fb.gap  = sender_idle ? int'($urandom_range(0, 11)) : 0;
      byte_queue.push_back(fb);
      sent_image[gen_pos] = fb.pix;
      gen_pos = fb.fend ? 0 : (gen_pos + 1) % STORE_DEPTH;
    end
    flip_marks.delete();
    frames_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_if.valid || expected_refresh.size() != 0);
    // Leave margin after the last request is taken.
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int random_bytes;
    int len;
    int rate;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.pixel_byte = '0;
    in_if.frame_end  = 1'b0;
    out_if.ready     = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    errors           = 0;
    frames_queued    = 0;
    bytes_accepted   = 0;
    cfg_writes       = 0;
    hold_on          = 1'b0;
    gen_pos          = 0;
    sender_idle      = 1'b0;
    receiver_idle    = 1'b1;
    foreach (mode_count[i]) mode_count[i] = 0;
    foreach (sent_image[i]) sent_image[i] = BYTE_W'($urandom_range(0, 255));
    last_valid = 1'b0;
    last_rot   = 1'b0;
    cfg_rot    = 1'b0;
    cfg_part   = 1'b0;
    clear_box();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // The longest frame of the run goes first; its request is always full.
    set_register(REG_ROTATION, 1'b0);
    set_register(REG_PARTIAL, 1'b0);
    queue_frame(MAX_FRAME, 1000);
    wait_drained();

    set_register(REG_PARTIAL, 1'b1);
    receiver_idle = 1'b0;
    queue_frame(1, 0);                  // unchanged: no refresh
    queue_frame(1, 1000);               // top-left byte only
    flip_marks = '{ROW_BYTES - 1};
    queue_frame(ROW_BYTES, 0);          // last column of the first row
    wait_drained();

    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    // Narrow box down six rows, then a full-width box over the same rows.
    flip_marks = '{0, 5 * ROW_BYTES};
    queue_frame(6 * ROW_BYTES, 0);
    sender_idle = 1'b0;
    flip_marks = '{0, 6 * ROW_BYTES - 1};
    queue_frame(6 * ROW_BYTES, 0);
    wait_drained();

    set_register(REG_ROTATION, 1'b1);
    queue_frame(1, 0);                  // rotation changed: full
    flip_marks = '{0};
    queue_frame(ROW_BYTES, 0);
    flip_marks = '{ROW_BYTES - 1};
    queue_frame(ROW_BYTES * 2, 0);
    queue_frame(5, 0);
    wait_drained();

    set_register(REG_PARTIAL, 1'b0);
    queue_frame(3, 0);
    wait_drained();

    // Receiver holds off while single-byte frames pile up behind it.
    set_register(REG_PARTIAL, 1'b1);
    hold_on = 1'b1;
    repeat (20) queue_frame(1, 500);
    repeat (300) @(negedge clk);
    hold_on = 1'b0;
    wait_drained();

    random_bytes = 0;
    while (random_bytes < 330) begin
      sender_idle   = ($urandom_range(0, 2) != 0);
      receiver_idle = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 2) == 0) set_register(REG_ROTATION, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) set_register(REG_PARTIAL, ($urandom_range(0, 3) != 0));
      repeat ($urandom_range(3, 8)) begin
        len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(41, MAX_FRAME))
                                          : int'($urandom_range(1, 40));
        case ($urandom_range(0, 3))
          0: rate = 0;
          1: rate = 10;
          2: rate = 80;
          default: rate = 1000;
        endcase
        queue_frame(len, rate);
        random_bytes += len;
      end
      wait_drained();
    end

    errors += expected_refresh.size();
    $display("Run covered %0d frames, %0d bytes, %0d register writes.",
             frames_queued, bytes_accepted, cfg_writes);
    $display("Requests seen: %0d none, %0d partial, %0d full.",
             mode_count[MODE_NONE], mode_count[MODE_PARTIAL], mode_count[MODE_FULL]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // About 900 bytes with random gaps, plus the long hold, register
  // writes and drains, take well under half a millisecond.
  initial begin
    #4_000_000;
    $display("Timed out with %0d requests outstanding", expected_refresh.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
